### design/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared codes and types for the bounded message fifo with remove.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// operation codes of an input word
	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// capacity register
	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} bfr_status_t;

	// control sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_GET_WAIT,
		S_RM_SCAN,
		S_RM_END
	} bfr_state_t;

endpackage

### design/bfr_ram.sv
// ----------------------------------------------------------------------------
// bfr_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/bfr_result_buf.sv
// ----------------------------------------------------------------------------
// bfr_result_buf
// Output register with a skid stage, so a finished result never blocks the
// sequencer while the previous one waits to be taken.
// ----------------------------------------------------------------------------
module bfr_result_buf #(
	parameter int W = 39
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic [W-1:0] out_data_q;
	logic         skid_valid_q;
	logic [W-1:0] skid_data_q;
	logic         pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (!out_valid_q) begin
			if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

### design/bounded_fifo_with_remove.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_remove
// Message fifo with a programmable capacity limit and remove-by-value.
// ----------------------------------------------------------------------------
// The entries live in one dual-port RAM used as a ring between a head and a
// tail pointer, and every word gives one result. A put, a get on an empty
// queue and an unused code finish in the cycle they are taken; a get waits
// in S_GET_WAIT for the registered RAM read. A remove streams the stored
// entries through the RAM read port, one per cycle, and writes the kept ones
// back at a trailing pointer, then gives its result from S_RM_END. The RAM is
// not cleared after reset; only entries below the count are ever read.
// Results go through an output register with a skid stage; once both hold
// a word the input stalls until the receiver takes one.
// ----------------------------------------------------------------------------
module bounded_fifo_with_remove
	import bfr_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int MESSAGE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [CAP_W-1:0]                   cfg_data,
	// input words
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         operation,
	input  logic [MESSAGE_WIDTH-1:0]           message,
	// result words
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [MESSAGE_WIDTH-1:0]           message_out,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;
	localparam int RW = 2 + MESSAGE_WIDTH + CW;
	localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

	bfr_state_t state_q, state_d;

	logic [CAP_W-1:0]         limit_q;
	logic [AW-1:0]            head_q, tail_q;
	logic [CW-1:0]            count_q;
	logic [MESSAGE_WIDTH-1:0] msg_q;
	logic [CW-1:0]            rd_idx_q;
	logic [AW-1:0]            rd_addr_q, wr_addr_q;
	logic [CW-1:0]            kept_q;
	logic                     found_q;
	logic                     vld_s1;

	logic                     accept;
	logic                     res_full;
	logic                     push;
	bfr_status_t              push_status;
	logic [MESSAGE_WIDTH-1:0] push_msg;
	logic [CW-1:0]            push_count;
	logic [RW-1:0]            out_data;

	logic                     ram_we, ram_re;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [MESSAGE_WIDTH-1:0] ram_wdata, ram_rdata;

	logic [LW-1:0]            eff_limit;
	logic                     full_now;
	logic                     s1_match;

	// ring pointer increment with wrap at the depth
	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == LAST_ADDR) ? '0 : p + AW'(1);
	endfunction

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign s1_match  = (ram_rdata == msg_q);

	// effective limit: zero acts as one, saturates at the depth
	always_comb begin
		if (limit_q == '0) begin
			eff_limit = LW'(1);
		end else if (LW'(limit_q) > LW'(QUEUE_DEPTH)) begin
			eff_limit = LW'(QUEUE_DEPTH);
		end else begin
			eff_limit = LW'(limit_q);
		end
	end

	assign full_now = (count_q != '0) && (LW'(count_q) >= eff_limit);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_GET && count_q != '0) begin
						state_d = S_GET_WAIT;
					end else if (operation == OP_REMOVE) begin
						state_d = S_RM_SCAN;
					end
				end
			end
			S_GET_WAIT: begin
				if (!res_full) begin
					state_d = S_IDLE;
				end
			end
			S_RM_SCAN: begin
				if (rd_idx_q == count_q && !vld_s1) begin
					state_d = S_RM_END;
				end
			end
			S_RM_END: begin
				if (!res_full) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: ram access, result push, input stall
	always_comb begin
		in_stall    = 1'b1;
		push        = 1'b0;
		push_status = ST_DONE;
		push_msg    = '0;
		push_count  = count_q;
		ram_we      = 1'b0;
		ram_waddr   = tail_q;
		ram_wdata   = message;
		ram_re      = 1'b0;
		ram_raddr   = head_q;
		unique case (state_q)
			S_IDLE: begin
				in_stall = res_full;
				if (accept) begin
					unique case (operation)
						OP_PUT: begin
							push = 1'b1;
							if (full_now) begin
								push_status = ST_FULL;
							end else begin
								ram_we     = 1'b1;
								push_count = count_q + CW'(1);
							end
						end
						OP_GET: begin
							if (count_q == '0) begin
								push        = 1'b1;
								push_status = ST_EMPTY;
							end else begin
								ram_re = 1'b1;
							end
						end
						OP_REMOVE: begin
							push = 1'b0;
						end
						default: begin
							push = 1'b1;
						end
					endcase
				end
			end
			S_GET_WAIT: begin
				if (!res_full) begin
					push       = 1'b1;
					push_msg   = ram_rdata;
					push_count = count_q - CW'(1);
				end
			end
			S_RM_SCAN: begin
				if (rd_idx_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = rd_addr_q;
				end
				if (vld_s1 && !s1_match) begin
					ram_we    = 1'b1;
					ram_waddr = wr_addr_q;
					ram_wdata = ram_rdata;
				end
			end
			S_RM_END: begin
				if (!res_full) begin
					push        = 1'b1;
					push_status = found_q ? ST_DONE : ST_NOT_FOUND;
					push_count  = kept_q;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// state, pointers, count and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			limit_q   <= CAP_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_addr_q <= '0;
			wr_addr_q <= '0;
			kept_q    <= '0;
			found_q   <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_PUT && !full_now) begin
						tail_q  <= ptr_next(tail_q);
						count_q <= count_q + CW'(1);
					end
					if (accept && operation == OP_REMOVE) begin
						rd_idx_q  <= '0;
						rd_addr_q <= head_q;
						wr_addr_q <= head_q;
						kept_q    <= '0;
						found_q   <= 1'b0;
						vld_s1    <= 1'b0;
					end
				end
				S_GET_WAIT: begin
					if (push) begin
						head_q  <= ptr_next(head_q);
						count_q <= count_q - CW'(1);
					end
				end
				S_RM_SCAN: begin
					vld_s1 <= ram_re;
					if (ram_re) begin
						rd_idx_q  <= rd_idx_q + CW'(1);
						rd_addr_q <= ptr_next(rd_addr_q);
					end
					if (vld_s1) begin
						if (s1_match) begin
							found_q <= 1'b1;
						end else begin
							wr_addr_q <= ptr_next(wr_addr_q);
							kept_q    <= kept_q + CW'(1);
						end
					end
				end
				S_RM_END: begin
					if (push) begin
						count_q <= kept_q;
						tail_q  <= wr_addr_q;
					end
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// handle being matched during a remove
	always_ff @(posedge clk) begin
		if (accept && operation == OP_REMOVE) begin
			msg_q <= message;
		end
	end

	// entry storage
	bfr_ram #(
		.WIDTH (MESSAGE_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result output with skid
	bfr_result_buf #(
		.W (RW)
	) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_status, push_msg, push_count}),
		.full      (res_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign status      = out_data[RW-1 -: 2];
	assign message_out = out_data[CW +: MESSAGE_WIDTH];
	assign count       = out_data[CW-1:0];

endmodule

### bench/bounded_fifo_with_remove_tb.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_remove_tb
// Self-checking bench for the bounded message fifo with remove-by-value.
// Drives put, get and remove words under random idling and back pressure.
// A small queue mirror predicts each result word. Every result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_fifo_with_remove_tb
	import bfr_pkg::*;
();

	localparam int DEPTH = 16;
	localparam int MW = 32;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam int SEG_WORDS = 310;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		bfr_status_t    status;
		logic [MW-1:0]  message;
		logic [CW-1:0]  count;
	} fifo_result_t;

	// mirror of the queue contents and the capacity register
	class queue_mirror;
		logic [MW-1:0]    held[$];
		logic [CAP_W-1:0] cap_reg;
		fifo_result_t     expected_words[$];
		int               mismatches;
		int               checked;
		int               n_full;
		int               n_empty;
		int               n_missing;

		function new();
			cap_reg = CAP_RESET;
		endfunction

		function void write_limit(logic [CAP_W-1:0] v);
			cap_reg = v;
		endfunction

		// predict the result of one accepted input word
		function void note_word(logic [1:0] op, logic [MW-1:0] msg);
			fifo_result_t  r;
			logic [MW-1:0] kept[$];
			int unsigned   lim;
			bit            found;
			lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
			found = 1'b0;
			r.status = ST_DONE;
			r.message = '0;
			unique case (op)
				OP_PUT: begin
					if (held.size() >= lim) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						held.push_back(msg);
					end
				end
				OP_GET: begin
					if (held.size() == 0) begin
						r.status = ST_EMPTY;
						n_empty++;
					end else begin
						r.message = held.pop_front();
					end
				end
				OP_REMOVE: begin
					// drop every copy, keep the order of the rest
					foreach (held[i]) begin
						if (held[i] == msg)
							found = 1'b1;
						else
							kept.push_back(held[i]);
					end
					held = kept;
					if (!found) begin
						r.status = ST_NOT_FOUND;
						n_missing++;
					end
				end
				default: ;
			endcase
			r.count = CW'(held.size());
			expected_words.push_back(r);
		endfunction

		// compare one accepted result word with the oldest prediction
		function void check_word(logic [1:0] st, logic [MW-1:0] msg, logic [CW-1:0] cnt);
			fifo_result_t e;
			checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result word: status %0d message %h count %0d",
						st, msg, cnt);
				return;
			end
			e = expected_words.pop_front();
			if (st !== e.status || msg !== e.message || cnt !== e.count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: status %0d/%0d message %h/%h count %0d/%0d (exp/got)",
						checked, e.status, st, e.message, msg, e.count, cnt);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       operation = OP_PUT;
	logic [MW-1:0]    message = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic [MW-1:0]    message_out;
	logic [CW-1:0]    count;

	queue_mirror   mirror = new();
	logic [MW-1:0] msg_pool[4];
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	bit            hold_request = 1'b0;
	bit            hold_taken = 1'b0;
	int            hold_left = 0;
	int            cycles = 0;
	int            in_blocked = 0;
	int            out_blocked = 0;
	int            words_sent = 0;
	int            n_settings = 0;

	bounded_fifo_with_remove #(
		.QUEUE_DEPTH   (DEPTH),
		.MESSAGE_WIDTH (MW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.message     (message),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.message_out (message_out),
		.count       (count)
	);

	always #5 clk = ~clk;

	// cycle and stall statistics
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && in_stall)
			in_blocked <= in_blocked + 1;
		if (out_valid && out_stall)
			out_blocked <= out_blocked + 1;
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycles, mirror.expected_words.size());
		$display("FAIL bounded_fifo_with_remove");
		$finish;
	end

	// result side: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_taken) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.check_word(status, message_out, count);
	end

	// offer one word, hold it until taken, then predict its result
	task automatic send_word(logic [1:0] op, logic [MW-1:0] msg);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		message <= msg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		mirror.note_word(op, msg);
		words_sent++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mirror.expected_words.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	// capacity register write, only while the block is idle
	task automatic write_cap(logic [CAP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		mirror.write_limit(v);
		n_settings++;
	endtask

	// mostly handles from a small pool so removes find matches
	function automatic logic [MW-1:0] pick_message();
		if ($urandom_range(9) < 7)
			return msg_pool[$urandom_range(3)];
		return $urandom;
	endfunction

	// random words in blocks that alternately fill and drain the queue
	task automatic run_segment(int tx_pct, int rx_pct, logic [CAP_W-1:0] cap, bit squeeze);
		int         r;
		bit         fill;
		logic [1:0] op;
		fill = 1'b0;
		write_cap(cap);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		foreach (msg_pool[i])
			msg_pool[i] = $urandom;
		msg_pool[0] = $urandom_range(1) ? '0 : '1;
		for (int n = 0; n < SEG_WORDS; n++) begin
			if (n % 32 == 0)
				fill = ~fill;
			if (squeeze && n == 40)
				hold_request <= 1'b1;
			r = $urandom_range(99);
			if (fill)
				op = (r < 55) ? OP_PUT : (r < 75) ? OP_GET : (r < 95) ? OP_REMOVE : OP_UNUSED;
			else
				op = (r < 20) ? OP_PUT : (r < 60) ? OP_GET : (r < 95) ? OP_REMOVE : OP_UNUSED;
			send_word(op, pick_message());
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases under the reset capacity
		send_word(OP_GET, '0);
		send_word(OP_REMOVE, '0);
		send_word(OP_UNUSED, '1);
		// extremes and duplicates
		send_word(OP_PUT, '0);
		send_word(OP_PUT, '1);
		send_word(OP_PUT, 32'hA5A5_5A5A);
		send_word(OP_PUT, 32'hA5A5_5A5A);
		send_word(OP_PUT, '0);
		send_word(OP_PUT, 32'hA5A5_5A5A);
		send_word(OP_UNUSED, 32'h1234_5678);
		// remove hitting the front entry, then adjacent copies, then nothing
		send_word(OP_REMOVE, '0);
		send_word(OP_REMOVE, 32'hA5A5_5A5A);
		send_word(OP_REMOVE, 32'h0000_0001);
		send_word(OP_GET, '0);
		send_word(OP_GET, '0);
		drain();

		// zero capacity acts as one
		write_cap(5'd0);
		send_word(OP_PUT, 32'h8000_0001);
		send_word(OP_PUT, 32'h7FFF_FFFE);
		send_word(OP_GET, '0);
		drain();

		// small capacity: reject, remove, get
		write_cap(5'd2);
		send_word(OP_PUT, 32'h0000_0001);
		send_word(OP_PUT, 32'h0000_0002);
		send_word(OP_PUT, 32'h0000_0003);
		send_word(OP_REMOVE, 32'h0000_0001);
		send_word(OP_GET, '0);
		drain();

		// random part: sender light and receiver heavy, then reversed, then none
		run_segment(16, 60, 5'd16, 1'b0);
		run_segment(16, 60, 5'd1, 1'b0);
		run_segment(60, 16, 5'd0, 1'b0);
		run_segment(60, 16, 5'($urandom_range(15, 2)), 1'b0);
		run_segment(0, 0, 5'd31, 1'b1);
		run_segment(0, 0, 5'($urandom_range(30, 17)), 1'b0);

		$display("covered %0d words, %0d limits: %0d full puts, %0d empty gets, %0d missed",
			words_sent, n_settings, mirror.n_full, mirror.n_empty, mirror.n_missing);
		$display("input held back %0d cycles, results held back %0d cycles, %0d mismatches",
			in_blocked, out_blocked, mirror.mismatches);
		if (mirror.mismatches == 0 && mirror.expected_words.size() == 0)
			$display("PASS bounded_fifo_with_remove");
		else
			$display("FAIL bounded_fifo_with_remove");
		$finish;
	end

endmodule
